>>> rtl/dmxl_pkg.sv
// Shared types and constants for the DMX channel safety limiter.
`default_nettype none
package dmxl_pkg;

	// Store geometry.
	localparam int NUM_UNIVERSES         = 4;
	localparam int CHANNELS_PER_UNIVERSE = 512;
	localparam int STORE_SIZE            = NUM_UNIVERSES * CHANNELS_PER_UNIVERSE;
	localparam int IDX_W                 = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
	localparam int UNI_W                 = $clog2(NUM_UNIVERSES + 1);

	// Idle counter saturates at its all-ones value.
	localparam int               IDLE_W   = 17;
	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

	// A slew step of this value disables slew limiting.
	localparam logic [7:0] SLEW_OFF = 8'd255;

	// Command kinds.
	typedef enum logic [2:0] {
		KIND_WRITE    = 3'd0,
		KIND_TICK     = 3'd1,
		KIND_READ     = 3'd2,
		KIND_BLACKOUT = 3'd3,
		KIND_FREEZE   = 3'd4
	} kind_t;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ADDR = 2'd1;
	localparam logic [1:0] ST_TRIP = 2'd2;

	// Configuration register indexes.
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CEILING = 2'd0;
	localparam cfg_idx_t CFG_STEP    = 2'd1;
	localparam cfg_idx_t CFG_TIMEOUT = 2'd2;

	typedef logic [IDX_W-1:0] mem_idx_t;

	// Input command.
	typedef struct packed {
		logic [2:0]         kind;
		logic [15:0]        universe;
		logic [9:0]         address;
		logic signed [15:0] requested_level;
		logic               flag;
	} cmd_t;

	// Result item.
	typedef struct packed {
		logic [2:0] out_universe;
		logic [9:0] out_address;
		logic [7:0] channel_level;
		logic [1:0] status;
		logic       blackout_active;
	} res_t;

	// Write request into the level store.
	typedef struct packed {
		logic     en;
		mem_idx_t idx;
		logic [7:0] data;
	} mem_wr_t;

endpackage
`default_nettype wire

>>> rtl/dmxl_level_mem.sv
// Channel level store: one write port and one registered read port.
`default_nettype none
module dmxl_level_mem (
	input  logic              clk,
	input  dmxl_pkg::mem_wr_t wr,
	input  dmxl_pkg::mem_idx_t rd_idx,
	output logic [7:0]        rd_data
);
	import dmxl_pkg::*;

	logic [7:0] mem [STORE_SIZE];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
	end

	// Registered read, returns the old contents on a same-cycle write.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_idx];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

>>> rtl/dmxl_core.sv
// Command decode, safety limiting, control latches and result register.
`default_nettype none
module dmxl_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  dmxl_pkg::cmd_t      command,
	input  logic                cfg_we,
	input  dmxl_pkg::cfg_idx_t  cfg_index,
	input  logic [15:0]         cfg_data,
	output dmxl_pkg::mem_idx_t  rd_idx,
	input  logic [7:0]          rd_data,
	output dmxl_pkg::mem_wr_t   wr_req,
	output logic                done,
	output dmxl_pkg::res_t      result
);
	import dmxl_pkg::*;

	// Clamp to the ceiling, then to the slew window around the current level; blackout forces zero.
	function automatic logic [7:0] limit_level(input logic [7:0] cur,
			input logic signed [15:0] req, input logic [7:0] ceil_v,
			input logic [7:0] step, input logic blk);
		logic [7:0] v;
		logic [7:0] lo;
		logic [8:0] hi;
		if (req < 0) begin
			v = 8'd0;
		end else if (req[15:8] != 8'd0 || req[7:0] > ceil_v) begin
			v = ceil_v;
		end else begin
			v = req[7:0];
		end
		if (step != SLEW_OFF) begin
			lo = (cur < step) ? 8'd0 : cur - step;
			hi = {1'b0, cur} + {1'b0, step};
			if (hi > {1'b0, ceil_v}) begin
				hi = {1'b0, ceil_v};
			end
			if (v < lo) begin
				v = lo;
			end
			if ({1'b0, v} > hi) begin
				v = hi[7:0];
			end
		end
		if (blk) begin
			v = 8'd0;
		end
		return v;
	endfunction

	logic [UNI_W-1:0] uni_c;
	logic             addr_ok;

	// Sanitize the universe and check the address of the incoming command.
	always_comb begin
		if (command.universe == 16'd0) begin
			uni_c = UNI_W'(1);
		end else if (command.universe > 16'(NUM_UNIVERSES)) begin
			uni_c = UNI_W'(NUM_UNIVERSES);
		end else begin
			uni_c = UNI_W'(command.universe);
		end
		addr_ok = (command.address != 10'd0) &&
			(command.address <= 10'(CHANNELS_PER_UNIVERSE));
		rd_idx = IDX_W'((32'(uni_c) - 32'd1) * CHANNELS_PER_UNIVERSE +
			32'(command.address) - 32'd1);
	end

	// Stage one registers, aligned with the store's read data.
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [UNI_W-1:0] uni_s1;
	logic             addr_ok_s1;
	mem_idx_t         idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= command;
			uni_s1     <= uni_c;
			addr_ok_s1 <= addr_ok;
			idx_s1     <= rd_idx;
		end
	end

	// Configuration and control state.
	logic [7:0]        ceiling_q;
	logic [7:0]        step_q;
	logic [15:0]       timeout_q;
	logic              blackout_q;
	logic              freeze_q;
	logic [IDLE_W-1:0] idle_q;
	logic              seen_q;

	// Last store write, forwarded to a command that read the same entry too early.
	logic       fwd_valid_q;
	mem_idx_t   fwd_idx_q;
	logic [7:0] fwd_data_q;

	logic [7:0]        cur;
	logic [7:0]        limited;
	logic [7:0]        level_n;
	logic [1:0]        status_n;
	logic              wr_en;
	logic              blackout_n;
	logic              freeze_n;
	logic [IDLE_W-1:0] idle_n;
	logic [IDLE_W-1:0] idle_inc;
	logic              seen_n;

	// Command execution for the transaction in stage one.
	always_comb begin
		cur = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_data_q : rd_data;
		limited = limit_level(cur, cmd_s1.requested_level, ceiling_q, step_q, blackout_q);
		idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + IDLE_W'(1);
		level_n = 8'd0;
		status_n = ST_OK;
		wr_en = 1'b0;
		blackout_n = blackout_q;
		freeze_n = freeze_q;
		idle_n = idle_q;
		seen_n = seen_q;
		if (valid_s1) begin
			unique case (kind_t'(cmd_s1.kind))
				KIND_WRITE: begin
					idle_n = '0;
					seen_n = 1'b1;
					if (!addr_ok_s1) begin
						if (!freeze_q) begin
							status_n = ST_ADDR;
						end
					end else begin
						wr_en = !freeze_q;
						if (blackout_q) begin
							level_n = 8'd0;
						end else begin
							level_n = freeze_q ? cur : limited;
						end
					end
				end
				KIND_TICK: begin
					idle_n = idle_inc;
					if (timeout_q != 16'd0 && seen_q && !blackout_q &&
							idle_inc > IDLE_W'(timeout_q)) begin
						blackout_n = 1'b1;
						status_n = ST_TRIP;
					end
				end
				KIND_READ: begin
					if (!addr_ok_s1) begin
						status_n = ST_ADDR;
					end else begin
						level_n = blackout_q ? 8'd0 : cur;
					end
				end
				KIND_BLACKOUT: begin
					blackout_n = cmd_s1.flag;
				end
				KIND_FREEZE: begin
					freeze_n = cmd_s1.flag;
				end
				default: begin
				end
			endcase
		end
	end

	assign wr_req = '{en: wr_en, idx: idx_s1, data: limited};

	// Control state, configuration and forwarding registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q   <= 8'd255;
			step_q      <= SLEW_OFF;
			timeout_q   <= 16'd0;
			blackout_q  <= 1'b0;
			freeze_q    <= 1'b0;
			idle_q      <= '0;
			seen_q      <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			blackout_q  <= blackout_n;
			freeze_q    <= freeze_n;
			idle_q      <= idle_n;
			seen_q      <= seen_n;
			fwd_valid_q <= wr_en;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CEILING: ceiling_q <= cfg_data[7:0];
					CFG_STEP:    step_q    <= cfg_data[7:0];
					CFG_TIMEOUT: timeout_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_idx_q  <= idx_s1;
		fwd_data_q <= limited;
	end

	// Result register.
	logic done_s2;
	res_t result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2.out_universe    <= 3'(uni_s1);
			result_s2.out_address     <= cmd_s1.address;
			result_s2.channel_level   <= level_n;
			result_s2.status          <= status_n;
			result_s2.blackout_active <= blackout_n;
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

endmodule
`default_nettype wire

>>> rtl/dmx_channel_safety_limiter.sv
// Top level of the DMX channel safety limiter: clearing sequencer, store and core.
`default_nettype none
// A command is taken at any clock edge with start high and busy low, one per
// cycle if desired. Its result appears on result with done high for exactly
// one cycle, in command order, after passing the stage-one registers and the
// result register; the receiver cannot hold results off. The level store's
// registered read is followed by limiting and write-back; a write followed at
// once by an access to the same channel sees the new level through a
// one-entry bypass. After reset, busy stays high while the store is zeroed,
// one entry per cycle, over all STORE_SIZE entries (2048 with four universes
// of 512 channels). Configuration writes are always ready and should be
// issued only while no command is in flight.
module dmx_channel_safety_limiter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dmxl_pkg::cmd_t     command,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  dmxl_pkg::cfg_idx_t cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output dmxl_pkg::res_t     result
);
	import dmxl_pkg::*;

	logic     clr_busy_q;
	mem_idx_t clr_idx_q;
	logic     accept;
	mem_idx_t rd_idx;
	logic [7:0] rd_data;
	mem_wr_t  core_wr;
	mem_wr_t  mem_wr;

	// Clearing pass over the store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == IDX_W'(STORE_SIZE - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign busy      = clr_busy_q;
	assign cfg_ready = 1'b1;
	assign accept    = start && !clr_busy_q;

	// Store write port: zeros during clearing, otherwise the core's write-back.
	always_comb begin
		if (clr_busy_q) begin
			mem_wr = '{en: 1'b1, idx: clr_idx_q, data: 8'd0};
		end else begin
			mem_wr = core_wr;
		end
	end

	dmxl_level_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	dmxl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (command),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.wr_req    (core_wr),
		.done      (done),
		.result    (result)
	);

	// Every accepted transaction yields exactly one result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result without an accepted transaction");

	// The clearing pass ends only after the last entry.
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(clr_idx_q) == IDX_W'(STORE_SIZE - 1))
		else $error("clearing pass ended early");

	// A timeout trip always reports blackout, and an address error returns no level.
	a_trip_blackout: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_TRIP) |-> result.blackout_active)
		else $error("timeout trip without blackout");

	a_addr_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_ADDR) |-> result.channel_level == 8'd0)
		else $error("address error with nonzero level");

endmodule
`default_nettype wire

>>> tb/dmx_channel_safety_limiter_tb.sv
// Self-checking testbench for the DMX channel safety limiter, with directed and random commands.
module dmx_channel_safety_limiter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dmxl_pkg::*;

	// Kinds the block treats as no-ops.
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

	localparam int ITEMS_PER_PHASE = 230;
	localparam int WATCHDOG_LIMIT  = 10000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic       busy;
	cmd_t       command   = '0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_idx_t   cfg_index = CFG_CEILING;
	logic [15:0] cfg_data = '0;
	logic       done;
	res_t       result;

	// Predicted state of the limiter.
	logic [7:0]        level_store [STORE_SIZE];
	logic              blackout_on;
	logic              freeze_on;
	logic              activity_seen;
	logic [IDLE_W-1:0] idle_ms;
	logic [7:0]        ceiling_reg;
	logic [7:0]        step_reg;
	logic [15:0]       timeout_reg;

	cmd_t cmd_backlog[$];
	res_t expected_results[$];
	res_t want_result;
	int   cmds_queued     = 0;
	int   results_checked = 0;
	int   errors          = 0;
	int   gap_left        = 0;
	int   quiet_cycles    = 0;
	logic gaps_enabled    = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	dmx_channel_safety_limiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	// Clamp to the ceiling, then to the slew window around the stored level; blackout gives zero.
	function automatic logic [7:0] limited_level(logic [7:0] cur, int req);
		int v;
		int lo;
		int hi;
		if (blackout_on)
			return 8'd0;
		v = req;
		if (v < 0) v = 0;
		if (v > int'(ceiling_reg)) v = int'(ceiling_reg);
		if (step_reg != SLEW_OFF) begin
			lo = int'(cur) - int'(step_reg);
			hi = int'(cur) + int'(step_reg);
			if (lo < 0) lo = 0;
			if (hi > int'(ceiling_reg)) hi = int'(ceiling_reg);
			if (v < lo) v = lo;
			if (v > hi) v = hi;
		end
		return 8'(v);
	endfunction

	// Advance the predicted state by one command and return its result.
	function automatic res_t apply_command(cmd_t c);
		res_t r;
		int   uni;
		int   idx;
		logic addr_ok;
		r = '0;
		uni = int'(c.universe);
		if (uni < 1) uni = 1;
		if (uni > NUM_UNIVERSES) uni = NUM_UNIVERSES;
		addr_ok = (c.address >= 1) && (c.address <= CHANNELS_PER_UNIVERSE);
		idx = (uni - 1) * CHANNELS_PER_UNIVERSE + int'(c.address) - 1;
		case (c.kind)
			KIND_WRITE: begin
				// Every write counts as activity, even a frozen or misaddressed one.
				idle_ms = '0;
				activity_seen = 1'b1;
				if (!addr_ok) begin
					if (!freeze_on) r.status = ST_ADDR;
				end else begin
					if (!freeze_on)
						level_store[idx] = limited_level(level_store[idx],
							int'($signed(c.requested_level)));
					r.channel_level = blackout_on ? 8'd0 : level_store[idx];
				end
			end
			KIND_TICK: begin
				if (idle_ms != IDLE_MAX) idle_ms = idle_ms + 1'b1;
				if (timeout_reg != 16'd0 && activity_seen && !blackout_on &&
						idle_ms > timeout_reg) begin
					blackout_on = 1'b1;
					r.status = ST_TRIP;
				end
			end
			KIND_READ: begin
				if (!addr_ok) r.status = ST_ADDR;
				else r.channel_level = blackout_on ? 8'd0 : level_store[idx];
			end
			KIND_BLACKOUT: blackout_on = c.flag;
			KIND_FREEZE: freeze_on = c.flag;
			default: ;
		endcase
		r.out_universe = 3'(uni);
		r.out_address = c.address;
		r.blackout_active = blackout_on;
		return r;
	endfunction

	function automatic void queue_command(logic [2:0] kind, logic [15:0] uni, logic [9:0] addr,
			logic signed [15:0] req, logic flag);
		cmd_t c;
		c.kind = kind;
		c.universe = uni;
		c.address = addr;
		c.requested_level = req;
		c.flag = flag;
		cmd_backlog.push_back(c);
		cmds_queued++;
	endfunction

	// Random command, weighted toward a few hot channels so slew builds up.
	function automatic void queue_random_command();
		logic [2:0]         kind;
		logic [15:0]        uni;
		logic [9:0]         addr;
		logic signed [15:0] req;
		logic               flag;
		int                 pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) kind = KIND_WRITE;
		else if (pick < 62) kind = KIND_READ;
		else if (pick < 82) kind = KIND_TICK;
		else if (pick < 88) kind = KIND_BLACKOUT;
		else if (pick < 94) kind = KIND_FREEZE;
		else kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));

		pick = $urandom_range(0, 9);
		if (pick < 6) uni = 16'($urandom_range(1, 2));
		else if (pick < 8) uni = 16'($urandom_range(0, NUM_UNIVERSES + 1));
		else uni = 16'($urandom);

		pick = $urandom_range(0, 9);
		if (pick < 5) addr = 10'($urandom_range(1, 4));
		else if (pick < 6) addr = 10'(CHANNELS_PER_UNIVERSE);
		else if (pick < 8) addr = 10'($urandom_range(1, CHANNELS_PER_UNIVERSE));
		else addr = 10'($urandom);

		pick = $urandom_range(0, 9);
		if (pick < 6) req = 16'($urandom_range(0, 255));
		else if (pick < 7) req = 16'($urandom_range(256, 300));
		else if (pick < 8) req = 16'(-int'($urandom_range(1, 40)));
		else req = 16'($urandom);

		// Latch commands mostly clear, so blackout and freeze do not dominate.
		if (kind == KIND_BLACKOUT || kind == KIND_FREEZE)
			flag = ($urandom_range(0, 3) == 0);
		else
			flag = 1'($urandom);
		queue_command(kind, uni, addr, req, flag);
	endfunction

	// A write followed by ticks around the timeout, which may trip the deadman, then recovery.
	function automatic void queue_deadman_trip(int timeout);
		logic [15:0] uni;
		logic [9:0]  addr;
		int          ticks;
		uni = 16'($urandom_range(1, NUM_UNIVERSES));
		addr = 10'($urandom_range(1, CHANNELS_PER_UNIVERSE));
		ticks = timeout + $urandom_range(0, 2);
		queue_command(KIND_WRITE, uni, addr, 16'($urandom_range(0, 255)), 1'b0);
		repeat (ticks)
			queue_command(KIND_TICK, 16'($urandom), 10'($urandom), 16'($urandom), 1'($urandom));
		queue_command(KIND_READ, uni, addr, 16'sd0, 1'b0);
		queue_command(KIND_WRITE, uni, addr, 16'($urandom_range(0, 255)), 1'b0);
		queue_command(KIND_BLACKOUT, uni, addr, 16'sd0, 1'b0);
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	// Driver: present queued commands, with a random pause after each transaction when gaps are enabled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			command <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				expected_results.push_back(apply_command(command));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					command <= cmd_backlog.pop_front();
					start <= 1'b1;
					gap_left <= gaps_enabled ? $urandom_range(0, 8) : 0;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				$display("%0t ns: result with no transaction pending, expected none, actual %p",
					$time, result);
				errors++;
			end else begin
				want_result = expected_results.pop_front();
				check_field("out_universe", want_result.out_universe, result.out_universe);
				check_field("out_address", want_result.out_address, result.out_address);
				check_field("channel_level", want_result.channel_level, result.channel_level);
				check_field("status", want_result.status, result.status);
				check_field("blackout_active", want_result.blackout_active,
					result.blackout_active);
			end
		end
	end

	// Watchdog: give up after a long stretch with no transaction of any kind.
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Wait until every queued command has produced its result, then settle.
	task automatic wait_until_drained(int settle);
		do
			@(posedge clk);
		while (results_checked < cmds_queued);
		repeat (settle) @(posedge clk);
	endtask

	// Write one register; the caller lowers the valid after the last write.
	task automatic write_register(cfg_idx_t idx, logic [15:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_CEILING: ceiling_reg = value[7:0];
			CFG_STEP: step_reg = value[7:0];
			CFG_TIMEOUT: timeout_reg = value;
			default: ;
		endcase
	endtask

	// One setting of the registers followed by a block of random commands.
	task automatic run_phase(logic [7:0] ceiling, logic [7:0] step, logic [15:0] timeout,
			logic gaps);
		int target;
		wait_until_drained(4);
		write_register(CFG_CEILING, {8'd0, ceiling});
		write_register(CFG_STEP, {8'd0, step});
		write_register(CFG_TIMEOUT, timeout);
		cfg_valid <= 1'b0;
		gaps_enabled = gaps;
		target = cmds_queued + ITEMS_PER_PHASE;
		queue_command(KIND_BLACKOUT, 16'd1, 10'd1, 16'sd0, 1'b0);
		queue_command(KIND_FREEZE, 16'd1, 10'd1, 16'sd0, 1'b0);
		while (cmds_queued < target) begin
			if (timeout != 16'd0 && timeout < 16'd40 && $urandom_range(0, 9) == 0)
				queue_deadman_trip(int'(timeout));
			else
				queue_random_command();
		end
	endtask

	initial begin
		foreach (level_store[i]) level_store[i] = 8'd0;
		blackout_on = 1'b0;
		freeze_on = 1'b0;
		activity_seen = 1'b0;
		idle_ms = '0;
		ceiling_reg = 8'd255;
		step_reg = SLEW_OFF;
		timeout_reg = 16'd0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands under the reset settings.
		queue_command(KIND_READ, 16'd1, 10'd1, 16'sd0, 1'b0);
		queue_command(KIND_WRITE, 16'd0, 10'd1, 16'sh7FFF, 1'b0);
		queue_command(KIND_WRITE, 16'hFFFF, 10'd512, 16'sh8000, 1'b1);
		queue_command(KIND_WRITE, 16'd4, 10'd512, 16'sd200, 1'b0);
		queue_command(KIND_READ, 16'd9, 10'd512, 16'sd0, 1'b0);
		queue_command(KIND_WRITE, 16'd2, 10'd0, 16'sd10, 1'b0);
		queue_command(KIND_WRITE, 16'd2, 10'd513, 16'sd10, 1'b0);
		queue_command(KIND_WRITE, 16'd3, 10'd1023, 16'sd10, 1'b0);
		queue_command(KIND_READ, 16'd3, 10'd0, 16'sd0, 1'b0);
		queue_command(KIND_READ, 16'd3, 10'd1023, 16'sd0, 1'b0);
		queue_command(KIND_TICK, 16'd1, 10'd5, 16'sd0, 1'b0);
		// Frozen writes change nothing and report no address error.
		queue_command(KIND_FREEZE, 16'd1, 10'd1, 16'sd0, 1'b1);
		queue_command(KIND_WRITE, 16'd1, 10'd1, 16'sd5, 1'b0);
		queue_command(KIND_WRITE, 16'd1, 10'd0, 16'sd5, 1'b0);
		queue_command(KIND_FREEZE, 16'd1, 10'd1, 16'sd0, 1'b0);
		// Blackout zeroes reads and stores zero on write.
		queue_command(KIND_BLACKOUT, 16'd1, 10'd1, 16'sd0, 1'b1);
		queue_command(KIND_READ, 16'd1, 10'd1, 16'sd0, 1'b0);
		queue_command(KIND_WRITE, 16'd1, 10'd2, 16'sd99, 1'b0);
		queue_command(KIND_BLACKOUT, 16'd1, 10'd2, 16'sd0, 1'b0);
		queue_command(KIND_READ, 16'd1, 10'd2, 16'sd0, 1'b0);
		// No-op kinds, then a write and read of the same channel back to back.
		queue_command(KIND_SPARE_FIRST, 16'hFFFF, 10'h3FF, 16'shFFFF, 1'b1);
		queue_command(KIND_SPARE_LAST, 16'd2, 10'd3, 16'sd1, 1'b0);
		queue_command(KIND_WRITE, 16'd2, 10'd7, 16'sd17, 1'b0);
		queue_command(KIND_READ, 16'd2, 10'd7, 16'sd0, 1'b0);

		// Random phases across the register settings, extremes included.
		run_phase(8'd0, 8'd0, 16'd0, 1'b0);
		run_phase(8'd255, 8'd0, 16'hFFFF, 1'b1);
		run_phase(8'd128, 8'd10, 16'd5, 1'b1);
		run_phase(8'd100, 8'd254, 16'd1, 1'b0);
		run_phase(8'd255, 8'd1, 16'd3, 1'b1);
		run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(1, 30)), 1'b1);
		run_phase(8'd200, SLEW_OFF, 16'd12, 1'b0);
		run_phase(8'd50, 8'd30, 16'd0, 1'b1);

		wait_until_drained(8);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> dmx_channel_safety_limiter.f
rtl/dmxl_pkg.sv
rtl/dmxl_level_mem.sv
rtl/dmxl_core.sv
rtl/dmx_channel_safety_limiter.sv
tb/dmx_channel_safety_limiter_tb.sv
